@@ hw/rtl/occ_pkg.sv @@
// occ_pkg: shared types, constants and helpers of the offline action coalescing cache
// used by every module of the block; depends on nothing
`default_nettype none

package occ_pkg;

    // queue geometry
    localparam int QUEUE_DEPTH = 8;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int POS_W       = CNT_W + 1;

    // field widths
    localparam int ACTION_W = 3;
    localparam int DELTA_W  = 17;
    localparam int CODE_W   = 16;
    localparam int INDEX_W  = 3;
    localparam int LEVEL_W  = 9;
    localparam int CT_W     = 17;
    localparam int LIMIT_W  = 16;
    localparam int SUM_W    = 18;

    localparam int LEVEL_BOUND = 254;
    localparam logic [LIMIT_W-1:0] CT_LIMIT_RESET = 16'd347;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TOGGLE = 3'd0,
        ACT_LEVEL  = 3'd1,
        ACT_CT     = 3'd2,
        ACT_PUSH   = 3'd3,
        ACT_CLEAR  = 3'd4,
        ACT_READ   = 3'd5
    } action_t;

    // decoded command for one item, step marks the cycle the item is applied
    typedef struct packed {
        logic step;
        logic toggle;
        logic level;
        logic ct;
        logic push;
        logic clear;
        logic read;
    } occ_op_t;

    // ring position wrap, value is known to stay below twice the depth
    function automatic logic [PTR_W-1:0] wrap_pos(input logic [POS_W-1:0] pos);
        logic [POS_W-1:0] fixed;
        fixed = (pos >= POS_W'(QUEUE_DEPTH)) ? pos - POS_W'(QUEUE_DEPTH) : pos;
        return fixed[PTR_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/occ_accum.sv @@
// occ_accum: toggle flag and the two saturating accumulators
// depends on occ_pkg
`default_nettype none

module occ_accum (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire occ_pkg::occ_op_t               op,
    input  wire logic signed [occ_pkg::DELTA_W-1:0] delta,
    input  wire logic [occ_pkg::LIMIT_W-1:0]    ct_limit,
    output logic                                toggle_next,
    output logic signed [occ_pkg::LEVEL_W-1:0]  level_next,
    output logic signed [occ_pkg::CT_W-1:0]     ct_next
);
    import occ_pkg::*;

    localparam logic signed [SUM_W-1:0] LVL_MAX = SUM_W'(LEVEL_BOUND);

    logic                      toggle_reg;
    logic signed [LEVEL_W-1:0] level_reg;
    logic signed [CT_W-1:0]    ct_reg;

    logic signed [SUM_W-1:0] delta_x;
    logic signed [SUM_W-1:0] lvl_sum;
    logic signed [SUM_W-1:0] ct_sum;
    logic signed [SUM_W-1:0] ct_max;
    logic signed [SUM_W-1:0] lvl_sat;
    logic signed [SUM_W-1:0] ct_sat;

    always_comb
    begin
        delta_x = {{(SUM_W-DELTA_W){delta[DELTA_W-1]}}, delta};
        lvl_sum = {{(SUM_W-LEVEL_W){level_reg[LEVEL_W-1]}}, level_reg} + delta_x;
        ct_sum  = {{(SUM_W-CT_W){ct_reg[CT_W-1]}}, ct_reg} + delta_x;
        ct_max  = $signed({{(SUM_W-LIMIT_W){1'b0}}, ct_limit});

        if (lvl_sum > LVL_MAX)
            lvl_sat = LVL_MAX;
        else if (lvl_sum < -LVL_MAX)
            lvl_sat = -LVL_MAX;
        else
            lvl_sat = lvl_sum;

        if (ct_sum > ct_max)
            ct_sat = ct_max;
        else if (ct_sum < -ct_max)
            ct_sat = -ct_max;
        else
            ct_sat = ct_sum;

        toggle_next = toggle_reg;
        level_next  = level_reg;
        ct_next     = ct_reg;
        if (op.clear)
        begin
            toggle_next = 1'b0;
            level_next  = '0;
            ct_next     = '0;
        end
        else
        begin
            if (op.toggle)
                toggle_next = 1'b1;
            if (op.level)
                level_next = lvl_sat[LEVEL_W-1:0];
            if (op.ct)
                ct_next = ct_sat[CT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            toggle_reg <= 1'b0;
            level_reg  <= '0;
            ct_reg     <= '0;
        end
        else if (op.step)
        begin
            toggle_reg <= toggle_next;
            level_reg  <= level_next;
            ct_reg     <= ct_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/occ_ring.sv @@
// occ_ring: ring queue of codes that overwrites the oldest entry when full
// depends on occ_pkg
`default_nettype none

module occ_ring (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire occ_pkg::occ_op_t              op,
    input  wire logic [occ_pkg::CODE_W-1:0]    code,
    input  wire logic [occ_pkg::INDEX_W-1:0]   index,
    output logic [occ_pkg::CNT_W-1:0]          count_next,
    output logic [occ_pkg::CODE_W-1:0]         entry_code,
    output logic                               entry_valid
);
    import occ_pkg::*;

    logic [CODE_W-1:0] store [QUEUE_DEPTH];
    logic [PTR_W-1:0]  oldest_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [PTR_W-1:0]  oldest_next;

    logic              full;
    logic [PTR_W-1:0]  wr_pos;
    logic [PTR_W-1:0]  rd_pos;
    logic              hit;

    always_comb
    begin
        full   = (count_reg == CNT_W'(QUEUE_DEPTH));
        wr_pos = full ? oldest_reg
                      : wrap_pos(POS_W'(oldest_reg) + POS_W'(count_reg));
        hit    = (POS_W'(index) < POS_W'(count_reg));
        rd_pos = wrap_pos(POS_W'(oldest_reg) + POS_W'(index));

        entry_valid = op.read && hit;
        entry_code  = entry_valid ? store[rd_pos] : '0;

        oldest_next = oldest_reg;
        count_next  = count_reg;
        if (op.clear)
        begin
            oldest_next = '0;
            count_next  = '0;
        end
        else if (op.push)
        begin
            if (full)
                oldest_next = wrap_pos(POS_W'(oldest_reg) + POS_W'(1));
            else
                count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oldest_reg <= '0;
            count_reg  <= '0;
        end
        else if (op.step)
        begin
            oldest_reg <= oldest_next;
            count_reg  <= count_next;
        end
    end

    // code storage, no reset: entries are only read once written
    always_ff @(posedge clk)
    begin
        if (op.step && op.push)
            store[wr_pos] <= code;
    end

endmodule

`default_nettype wire

@@ hw/rtl/offline_action_coalescing_cache.sv @@
// offline_action_coalescing_cache: top level with input register, decode and result register
// depends on occ_pkg, occ_accum and occ_ring
`default_nettype none

// Offline action coalescing cache. Each input item carries one action: record a
// pending toggle, add a signed delta to the level sum (saturating at +-254) or to
// the colour temperature sum (saturating at +-ct_limit), push a code into an
// eight-entry ring that drops the oldest code when full, clear everything, or
// read the code at an index counted from the oldest. Every item gives exactly one
// result that shows the state after the action; entry_code and entry_valid are
// only set by a read whose index is below queue_count. Throughput is one item per
// clock while the output is not stalled: the state loop (one saturating add or one
// ring pointer update) closes between the input register and the result register.
// An item goes from the input register to the result register, where out_valid
// rises, when the output is not stalled. The input and result registers form a
// two-deep buffer, so the input can take one more item while a finished result
// waits. cfg_wr_data writes ct_limit (reset 347) and is to be written only while
// no item is in flight; a new bound takes effect at the next ct action.

module offline_action_coalescing_cache (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // configuration
    input  wire logic                         cfg_wr_en,
    input  wire logic [occ_pkg::LIMIT_W-1:0]  cfg_wr_data,
    // input channel
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [occ_pkg::ACTION_W-1:0] action,
    input  wire logic signed [occ_pkg::DELTA_W-1:0] delta,
    input  wire logic [occ_pkg::CODE_W-1:0]   code,
    input  wire logic [occ_pkg::INDEX_W-1:0]  index,
    // result channel
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic                              toggle_pending,
    output logic signed [occ_pkg::LEVEL_W-1:0] level_sum,
    output logic signed [occ_pkg::CT_W-1:0]   ct_sum,
    output logic [occ_pkg::CNT_W-1:0]         queue_count,
    output logic                              is_empty,
    output logic [occ_pkg::CODE_W-1:0]        entry_code,
    output logic                              entry_valid
);
    import occ_pkg::*;

    // configuration register
    logic [LIMIT_W-1:0] ct_limit_reg;

    // input register
    logic                      in_full_reg;
    logic [ACTION_W-1:0]       action_reg;
    logic signed [DELTA_W-1:0] delta_reg;
    logic [CODE_W-1:0]         code_reg;
    logic [INDEX_W-1:0]        index_reg;

    // result register
    logic                      out_valid_reg;
    logic                      toggle_out_reg;
    logic signed [LEVEL_W-1:0] level_out_reg;
    logic signed [CT_W-1:0]    ct_out_reg;
    logic [CNT_W-1:0]          count_out_reg;
    logic                      empty_out_reg;
    logic [CODE_W-1:0]         entry_out_reg;
    logic                      entry_valid_out_reg;

    logic    fire;
    logic    in_take;
    occ_op_t op;

    logic                      toggle_next;
    logic signed [LEVEL_W-1:0] level_next;
    logic signed [CT_W-1:0]    ct_next;
    logic [CNT_W-1:0]          count_next;
    logic [CODE_W-1:0]         rd_code;
    logic                      rd_valid;
    logic                      empty_next;

    // the held item is applied when the result slot is free or being emptied
    assign fire     = in_full_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_full_reg && !fire;
    assign in_take  = in_valid && !in_stall;

    // action decode, unused codes leave the state alone
    always_comb
    begin
        op      = '0;
        op.step = fire;
        unique case (action_t'(action_reg))
            ACT_TOGGLE: op.toggle = 1'b1;
            ACT_LEVEL:  op.level  = 1'b1;
            ACT_CT:     op.ct     = 1'b1;
            ACT_PUSH:   op.push   = 1'b1;
            ACT_CLEAR:  op.clear  = 1'b1;
            ACT_READ:   op.read   = 1'b1;
            default:    ;
        endcase
    end

    occ_accum u_accum (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (op),
        .delta       (delta_reg),
        .ct_limit    (ct_limit_reg),
        .toggle_next (toggle_next),
        .level_next  (level_next),
        .ct_next     (ct_next)
    );

    occ_ring u_ring (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (op),
        .code        (code_reg),
        .index       (index_reg),
        .count_next  (count_next),
        .entry_code  (rd_code),
        .entry_valid (rd_valid)
    );

    // empty flag reflects the state after this item's action
    assign empty_next = !toggle_next && (level_next == '0) && (ct_next == '0)
                        && (count_next == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ct_limit_reg <= CT_LIMIT_RESET;
        else if (cfg_wr_en)
            ct_limit_reg <= cfg_wr_data;
    end

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_full_reg <= 1'b0;
        else if (in_take)
            in_full_reg <= 1'b1;
        else if (fire)
            in_full_reg <= 1'b0;
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            action_reg <= action;
            delta_reg  <= delta;
            code_reg   <= code;
            index_reg  <= index;
        end
    end

    // result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fire)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            toggle_out_reg      <= toggle_next;
            level_out_reg       <= level_next;
            ct_out_reg          <= ct_next;
            count_out_reg       <= count_next;
            empty_out_reg       <= empty_next;
            entry_out_reg       <= rd_code;
            entry_valid_out_reg <= rd_valid;
        end
    end

    assign out_valid      = out_valid_reg;
    assign toggle_pending = toggle_out_reg;
    assign level_sum      = level_out_reg;
    assign ct_sum         = ct_out_reg;
    assign queue_count    = count_out_reg;
    assign is_empty       = empty_out_reg;
    assign entry_code     = entry_out_reg;
    assign entry_valid    = entry_valid_out_reg;

endmodule

`default_nettype wire

@@ hw/rtl/occ_checker.sv @@
// occ_checker: port-level assertions for the offline action coalescing cache
// depends on occ_pkg; bound to offline_action_coalescing_cache below
`default_nettype none

module occ_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          out_valid,
    input  wire logic                          out_stall,
    input  wire logic                          toggle_pending,
    input  wire logic [occ_pkg::LEVEL_W-1:0]   level_sum,
    input  wire logic [occ_pkg::CT_W-1:0]      ct_sum,
    input  wire logic [occ_pkg::CNT_W-1:0]     queue_count,
    input  wire logic                          is_empty,
    input  wire logic [occ_pkg::CODE_W-1:0]    entry_code,
    input  wire logic                          entry_valid
);
    import occ_pkg::*;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // empty flag agrees with the rest of the result
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (is_empty == (!toggle_pending && level_sum == '0 &&
                                    ct_sum == '0 && queue_count == '0)))
        else $error("is_empty inconsistent with reported state");

    // a read that misses returns zero, a hit needs a non-empty queue
    a_entry: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (entry_valid ? (queue_count != '0) : (entry_code == '0)))
        else $error("entry fields inconsistent with queue count");

    // level sum and count stay within their bounds
    a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($signed(level_sum) <= LEVEL_BOUND &&
                       $signed(level_sum) >= -LEVEL_BOUND &&
                       queue_count <= CNT_W'(QUEUE_DEPTH)))
        else $error("level sum or queue count out of range");

endmodule

bind offline_action_coalescing_cache occ_checker u_occ_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .toggle_pending (toggle_pending),
    .level_sum      (level_sum),
    .ct_sum         (ct_sum),
    .queue_count    (queue_count),
    .is_empty       (is_empty),
    .entry_code     (entry_code),
    .entry_valid    (entry_valid)
);

`default_nettype wire
